/* rtl/lsqe_pkg.sv */
// Shared types and constants for the line segment quad expander.
package lsqe_pkg;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic        [31:0] oz;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic        [30:0] t;
  } seg_t;

  // word moving down the square root chain
  typedef struct packed {
    logic        valid;
    seg_t        seg;
    logic [63:0] val;
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_word_t;

  // word moving down the divider chain (px and py side by side)
  typedef struct packed {
    logic        valid;
    seg_t        seg;
    logic [31:0] len;
    logic [33:0] den;
    logic [30:0] nx;
    logic [30:0] ny;
    logic [33:0] rx;
    logic [33:0] ry;
    logic [30:0] qx;
    logic [30:0] qy;
  } div_word_t;

  localparam int SQRT_STEPS = 32;
  localparam int QUOT_STEPS = 31;

  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_BL = 2'd1;
  localparam logic [1:0] CORNER_BR = 2'd2;
  localparam logic [1:0] CORNER_TR = 2'd3;

  function automatic logic signed [33:0] sext34(input logic signed [31:0] v);
    return {{2{v[31]}}, v};
  endfunction

endpackage

/* rtl/line_segment_quad_expander.sv */
// Top level of the thick line segment to quad expander.
// Usage:
//   Input channel (in_*): one line segment per word, origin, direction and
//   thickness in Q16.16. Taken at a clock edge with in_valid high and
//   in_stall low.
//   Output channel (out_*): four corner words per segment, in the order
//   top-left, bottom-left, bottom-right, top-right; out_last marks the fourth.
//   Path: a taken segment runs through a square root chain of 32 cells and
//   a divider chain of 31 cells; each cell gives one result bit (a divider
//   cell one bit of each offset) per cycle while the chain is not frozen.
//   Rate: the output channel moves one corner word a cycle while out_stall
//   is low; the chains take a new segment while older ones are still in
//   flight.
//   Reset (rst_n low, synchronous) empties every stage; nothing is emitted.
//   While out_stall is high the output word holds. If the corner stage is
//   busy and a segment waits behind it, the chain freezes and in_stall rises.
module line_segment_quad_expander
  import lsqe_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [31:0] in_dir_x,
  input  logic signed [31:0] in_dir_y,
  input  logic [30:0]        in_thickness,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_corner_index,
  output logic signed [31:0] out_corner_x,
  output logic signed [31:0] out_corner_y,
  output logic signed [31:0] out_corner_z,
  output logic               out_normal_x_pos,
  output logic               out_normal_y_pos,
  output logic [31:0]        out_seg_length,
  output logic [30:0]        out_seg_width,
  output logic               out_last
);

  logic        adv;
  logic        free;

  logic        in_v_r;
  seg_t        in_seg_r;
  logic        sq_v_r;
  seg_t        sq_seg_r;
  logic [63:0] sqx_r;
  logic [63:0] sqy_r;
  logic [31:0] adx;
  logic [31:0] ady;

  sqrt_word_t  sc [SQRT_STEPS+1];
  sqrt_word_t  sc0_r;

  logic        pr_v_r;
  seg_t        pr_seg_r;
  logic [31:0] pr_len_r;
  logic [31:0] pr_lenp_r;
  logic [62:0] prodx_r;
  logic [62:0] prody_r;
  logic [31:0] len_w;
  logic [31:0] lenp_w;
  logic [31:0] magx;
  logic [31:0] magy;

  div_word_t   dc [QUOT_STEPS+1];
  div_word_t   dc0_r;
  logic [63:0] num_x;
  logic [63:0] num_y;

  assign adv      = !dc[QUOT_STEPS].valid || free;
  assign in_stall = !adv;

  always_comb begin
    adx = in_seg_r.dx[31] ? 32'(-in_seg_r.dx) : 32'(in_seg_r.dx);
    ady = in_seg_r.dy[31] ? 32'(-in_seg_r.dy) : 32'(in_seg_r.dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      sq_v_r <= 1'b0;
      pr_v_r <= 1'b0;
    end else if (adv) begin
      in_v_r <= in_valid;
      sq_v_r <= in_v_r;
      pr_v_r <= sc[SQRT_STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_seg_r <= '{ox: in_origin_x, oy: in_origin_y, oz: in_origin_z,
                    dx: in_dir_x, dy: in_dir_y, t: in_thickness};
      sq_seg_r <= in_seg_r;
      sqx_r    <= {32'd0, adx} * {32'd0, adx};
      sqy_r    <= {32'd0, ady} * {32'd0, ady};
      sc0_r.seg  <= sq_seg_r;
      sc0_r.val  <= sqx_r + sqy_r;
      sc0_r.rem  <= '0;
      sc0_r.root <= '0;
    end
    if (!rst_n) begin
      sc0_r.valid <= 1'b0;
    end else if (adv) begin
      sc0_r.valid <= sq_v_r;
    end
  end

  assign sc[0] = sc0_r;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    lsqe_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .d_i   (sc[i]),
      .d_o   (sc[i+1])
    );
  end

  // zero length falls back to cos 1, sin 0 with a unit divisor
  always_comb begin
    len_w  = sc[SQRT_STEPS].root;
    lenp_w = (len_w == '0) ? 32'd1 : len_w;
    magx   = sc[SQRT_STEPS].seg.dy[31] ? 32'(-sc[SQRT_STEPS].seg.dy)
                                       : 32'(sc[SQRT_STEPS].seg.dy);
    magy   = (len_w == '0) ? 32'd1
           : (sc[SQRT_STEPS].seg.dx[31] ? 32'(-sc[SQRT_STEPS].seg.dx)
                                        : 32'(sc[SQRT_STEPS].seg.dx));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pr_seg_r  <= sc[SQRT_STEPS].seg;
      pr_len_r  <= len_w;
      pr_lenp_r <= lenp_w;
      prodx_r   <= {32'd0, sc[SQRT_STEPS].seg.t} * {31'd0, magx};
      prody_r   <= {32'd0, sc[SQRT_STEPS].seg.t} * {31'd0, magy};
    end
  end

  // rounded quotient: (2*t*mag + 2*len) / (4*len)
  always_comb begin
    num_x = {prodx_r, 1'b0} + {31'd0, pr_lenp_r, 1'b0};
    num_y = {prody_r, 1'b0} + {31'd0, pr_lenp_r, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dc0_r.seg <= pr_seg_r;
      dc0_r.len <= pr_len_r;
      dc0_r.den <= {pr_lenp_r, 2'b00};
      dc0_r.rx  <= {1'b0, num_x[63:31]};
      dc0_r.ry  <= {1'b0, num_y[63:31]};
      dc0_r.nx  <= num_x[30:0];
      dc0_r.ny  <= num_y[30:0];
      dc0_r.qx  <= '0;
      dc0_r.qy  <= '0;
    end
    if (!rst_n) begin
      dc0_r.valid <= 1'b0;
    end else if (adv) begin
      dc0_r.valid <= pr_v_r;
    end
  end

  assign dc[0] = dc0_r;

  for (genvar j = 0; j < QUOT_STEPS; j++) begin : g_div
    lsqe_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .d_i   (dc[j]),
      .d_o   (dc[j+1])
    );
  end

  lsqe_corner_gen #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_corner (
    .clk              (clk),
    .rst_n            (rst_n),
    .d_i              (dc[QUOT_STEPS]),
    .free             (free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_corner_index (out_corner_index),
    .out_corner_x     (out_corner_x),
    .out_corner_y     (out_corner_y),
    .out_corner_z     (out_corner_z),
    .out_normal_x_pos (out_normal_x_pos),
    .out_normal_y_pos (out_normal_y_pos),
    .out_seg_length   (out_seg_length),
    .out_seg_width    (out_seg_width),
    .out_last         (out_last)
  );

  // corners of one segment follow each other without a gap
  a_corner_burst : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("corner burst broken");

  a_corner_order : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      out_corner_index == $past(out_corner_index) + 2'd1)
    else $error("corner order broken");

  a_len_steady : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      out_seg_length == $past(out_seg_length) && out_corner_z == $past(out_corner_z))
    else $error("segment data changed within a quad");

endmodule

/* rtl/lsqe_sqrt_cell.sv */
// One bit step of the integer square root chain.
module lsqe_sqrt_cell
  import lsqe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  sqrt_word_t d_i,
  output sqrt_word_t d_o
);

  sqrt_word_t cell_r;
  sqrt_word_t cell_nxt;
  logic [33:0] rem_sh;
  logic [33:0] trial;
  logic [33:0] diff;
  logic        ge;

  always_comb begin
    rem_sh        = {d_i.rem[31:0], d_i.val[63:62]};
    trial         = {d_i.root, 2'b01};
    ge            = rem_sh >= trial;
    diff          = rem_sh - trial;
    cell_nxt      = d_i;
    cell_nxt.val  = {d_i.val[61:0], 2'b00};
    cell_nxt.rem  = ge ? diff : rem_sh;
    cell_nxt.root = {d_i.root[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (adv) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_o = cell_r;

endmodule

/* rtl/lsqe_div_cell.sv */
// One quotient bit of the two offset dividers.
module lsqe_div_cell
  import lsqe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  div_word_t d_i,
  output div_word_t d_o
);

  div_word_t cell_r;
  div_word_t cell_nxt;
  logic [34:0] den_w;
  logic [34:0] rx_sh;
  logic [34:0] ry_sh;
  logic [34:0] dx_w;
  logic [34:0] dy_w;
  logic        gex;
  logic        gey;

  always_comb begin
    den_w       = {1'b0, d_i.den};
    rx_sh       = {d_i.rx, d_i.nx[30]};
    ry_sh       = {d_i.ry, d_i.ny[30]};
    gex         = rx_sh >= den_w;
    gey         = ry_sh >= den_w;
    dx_w        = rx_sh - den_w;
    dy_w        = ry_sh - den_w;
    cell_nxt    = d_i;
    cell_nxt.nx = {d_i.nx[29:0], 1'b0};
    cell_nxt.ny = {d_i.ny[29:0], 1'b0};
    cell_nxt.rx = gex ? dx_w[33:0] : rx_sh[33:0];
    cell_nxt.ry = gey ? dy_w[33:0] : ry_sh[33:0];
    cell_nxt.qx = {d_i.qx[29:0], gex};
    cell_nxt.qy = {d_i.qy[29:0], gey};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (adv) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_o = cell_r;

endmodule

/* rtl/lsqe_corner_gen.sv */
// Holds one finished segment and sends its four corners, one word a cycle while out_stall is low.
module lsqe_corner_gen
  import lsqe_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  div_word_t          d_i,
  output logic               free,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_corner_index,
  output logic signed [31:0] out_corner_x,
  output logic signed [31:0] out_corner_y,
  output logic signed [31:0] out_corner_z,
  output logic               out_normal_x_pos,
  output logic               out_normal_y_pos,
  output logic [31:0]        out_seg_length,
  output logic [30:0]        out_seg_width,
  output logic               out_last
);

  localparam int SAT_W = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam logic signed [33:0] SAT_HI = (34'sd1 <<< (SAT_W - 1)) - 34'sd1;
  localparam logic signed [33:0] SAT_LO = -(34'sd1 <<< (SAT_W - 1));

  logic               hold_r;
  logic [1:0]         k_r;
  seg_t               seg_r;
  logic [31:0]        len_r;
  logic signed [31:0] px_r;
  logic signed [31:0] py_r;
  logic signed [31:0] px_nxt;
  logic signed [31:0] py_nxt;

  logic               out_valid_r;
  logic [1:0]         idx_r;
  logic signed [31:0] cx_r;
  logic signed [31:0] cy_r;
  logic signed [31:0] cz_r;
  logic               nxp_r;
  logic               nyp_r;
  logic [31:0]        len_o_r;
  logic [30:0]        wid_r;
  logic               last_r;

  logic               emit;
  logic               load;
  logic signed [33:0] sum_x;
  logic signed [33:0] sum_y;
  logic signed [31:0] cx_nxt;
  logic signed [31:0] cy_nxt;
  logic               far;
  logic               neg_px;
  logic               neg_py;

  assign emit = hold_r && (!out_valid_r || !out_stall);
  assign free = !hold_r || (emit && (k_r == CORNER_TR));
  assign load = d_i.valid && free;

  always_comb begin
    px_nxt = d_i.seg.dy[31] ? -$signed({1'b0, d_i.qx}) : $signed({1'b0, d_i.qx});
    py_nxt = d_i.seg.dx[31] ? -$signed({1'b0, d_i.qy}) : $signed({1'b0, d_i.qy});
  end

  // far end corners add the direction vector
  always_comb begin
    far    = (k_r == CORNER_BR) || (k_r == CORNER_TR);
    neg_px = (k_r == CORNER_TL) || (k_r == CORNER_TR);
    neg_py = (k_r == CORNER_BL) || (k_r == CORNER_BR);
    sum_x  = sext34(seg_r.ox) + (far ? sext34(seg_r.dx) : 34'sd0)
           + (neg_px ? -sext34(px_r) : sext34(px_r));
    sum_y  = sext34(seg_r.oy) + (far ? sext34(seg_r.dy) : 34'sd0)
           + (neg_py ? -sext34(py_r) : sext34(py_r));
    if (sum_x > SAT_HI)      cx_nxt = SAT_HI[31:0];
    else if (sum_x < SAT_LO) cx_nxt = SAT_LO[31:0];
    else                     cx_nxt = sum_x[31:0];
    if (sum_y > SAT_HI)      cy_nxt = SAT_HI[31:0];
    else if (sum_y < SAT_LO) cy_nxt = SAT_LO[31:0];
    else                     cy_nxt = sum_y[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r      <= 1'b0;
      k_r         <= CORNER_TL;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        hold_r <= 1'b1;
      end else if (emit && (k_r == CORNER_TR)) begin
        hold_r <= 1'b0;
      end
      if (emit) begin
        k_r <= k_r + 2'd1;
      end
      out_valid_r <= emit || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      seg_r <= d_i.seg;
      len_r <= d_i.len;
      px_r  <= px_nxt;
      py_r  <= py_nxt;
    end
    if (emit) begin
      idx_r   <= k_r;
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      cz_r    <= seg_r.oz;
      nxp_r   <= far;
      nyp_r   <= (k_r == CORNER_TL) || (k_r == CORNER_TR);
      len_o_r <= len_r;
      wid_r   <= seg_r.t;
      last_r  <= (k_r == CORNER_TR);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_corner_index = idx_r;
  assign out_corner_x     = cx_r;
  assign out_corner_y     = cy_r;
  assign out_corner_z     = cz_r;
  assign out_normal_x_pos = nxp_r;
  assign out_normal_y_pos = nyp_r;
  assign out_seg_length   = len_o_r;
  assign out_seg_width    = wid_r;
  assign out_last         = last_r;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the line segment quad expander.
`timescale 1ns / 100ps

module tb_top
  import lsqe_pkg::*;
;

  typedef struct {
    logic signed [31:0] ox, oy, oz, dx, dy;
    logic [30:0]        t;
  } seg_item_t;

  typedef struct {
    logic [1:0]         idx;
    logic signed [31:0] x, y, z;
    logic               nxp, nyp;
    logic [31:0]        len;
    logic [30:0]        w;
    logic               last;
  } corner_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [31:0] in_dir_x = '0, in_dir_y = '0;
  logic [30:0] in_thickness = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_corner_index;
  logic signed [31:0] out_corner_x, out_corner_y, out_corner_z;
  logic out_normal_x_pos, out_normal_y_pos, out_last;
  logic [31:0] out_seg_length;
  logic [30:0] out_seg_width;

  seg_item_t pending_segs[$];
  corner_t   expected_corners[$];
  int        mismatches = 0;
  int        cycles = 0;
  bit        stim_done = 0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        stall_mode = 0;

  line_segment_quad_expander uut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r[31:0];
  endfunction

  // round(t*d/den), ties away from zero
  function automatic longint half_offset(input longint t, input longint d,
                                         input longint den);
    logic [127:0] mag, q;
    mag = (d < 0) ? -d : d;
    q = (2 * (128'(t) * mag) + 128'(den)) / (2 * 128'(den));
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  task automatic expand_segment(input seg_item_t s);
    longint ox, oy, dx, dy, px, py, len;
    longint cx[4], cy[4];
    corner_t c;
    ox = s.ox; oy = s.oy; dx = s.dx; dy = s.dy;
    len = int_sqrt(64'(dx * dx) + 64'(dy * dy));
    if (len == 0) begin
      px = 0;
      py = half_offset(s.t, 1, 2);
    end else begin
      px = half_offset(s.t, dy, 2 * len);
      py = half_offset(s.t, dx, 2 * len);
    end
    cx[0] = ox - px;      cy[0] = oy + py;
    cx[1] = ox + px;      cy[1] = oy - py;
    cx[2] = ox + dx + px; cy[2] = oy + dy - py;
    cx[3] = ox + dx - px; cy[3] = oy + dy + py;
    for (int k = 0; k < 4; k++) begin
      c.idx  = k[1:0];
      c.x    = clamp32(cx[k]);
      c.y    = clamp32(cy[k]);
      c.z    = s.oz;
      c.nxp  = (c.idx == CORNER_BR) || (c.idx == CORNER_TR);
      c.nyp  = (c.idx == CORNER_TL) || (c.idx == CORNER_TR);
      c.len  = len[31:0];
      c.w    = s.t;
      c.last = (c.idx == CORNER_TR);
      expected_corners.push_back(c);
    end
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    mismatches++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000);
      3: return 32'($signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000);
      default: return 32'($signed($urandom_range(0, 32'h07ffffff)) - 32'sh04000000);
    endcase
  endfunction

  task automatic add_seg(input logic [31:0] ox, oy, oz, dx, dy, input logic [30:0] t);
    seg_item_t s;
    s.ox = ox; s.oy = oy; s.oz = oz; s.dx = dx; s.dy = dy; s.t = t;
    pending_segs.push_back(s);
  endtask

  initial begin
    seg_item_t s;
    // directed: zero length, extremes, axis directions, ties
    add_seg(0, 0, 0, 0, 0, 31'd0);
    add_seg(0, 0, 5, 0, 0, 31'd3);
    add_seg(32'h7fffffff, 32'h7fffffff, 32'hffffffff, 0, 0, 31'h7fffffff);
    add_seg(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 31'h7fffffff);
    add_seg(0, 0, 0, 32'h00010000, 0, 31'h00020000);
    add_seg(0, 0, 0, 0, 32'h00010000, 31'h00020000);
    add_seg(0, 0, 0, 32'hffff0000, 0, 31'h00020000);
    add_seg(0, 0, 0, 0, 32'hffff0000, 31'h00020000);
    add_seg(0, 0, 0, 32'h80000000, 32'h80000000, 31'h7fffffff);
    add_seg(0, 0, 0, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
    add_seg(32'h7fffffff, 32'h80000000, 1, 32'h7fffffff, 32'h80000000, 31'h7fffffff);
    add_seg(32'h80000000, 32'h7fffffff, 2, 32'h80000000, 32'h7fffffff, 31'h7fffffff);
    add_seg(32'h7ff00000, 32'h80100000, 3, 32'h00300000, 32'hffc00000, 31'h00100000);
    add_seg(100, -100, 7, 3, 4, 31'd5);
    add_seg(0, 0, 0, 1, 1, 31'd1);
    add_seg(0, 0, 0, 32'hffffffff, 32'hffffffff, 31'd1);
    add_seg(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
            31'h55555555);
    add_seg(32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555,
            31'h2aaaaaaa);
    for (int i = 0; i < 260; i++) begin
      s.ox = rand_coord(); s.oy = rand_coord(); s.oz = $urandom;
      s.dx = rand_coord(); s.dy = rand_coord();
      case ($urandom_range(0, 3))
        0: s.t = 31'($urandom);
        1: s.t = 31'($urandom_range(0, 32'h000fffff));
        default: s.t = 31'($urandom_range(0, 32'h7fffffff));
      endcase
      if ($urandom_range(0, 15) == 0) begin
        s.dx = 0; s.dy = 0;
      end
      pending_segs.push_back(s);
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // sender: bursts with gaps
  always @(posedge clk) begin
    seg_item_t s;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expand_segment(pending_segs.pop_front());
        if (burst_left > 0) burst_left--;
      end
      if (in_valid && in_stall) begin
        // hold word
      end else if (pending_segs.size() == 0) begin
        in_valid <= 1'b0;
        stim_done <= 1'b1;
      end else if (burst_left == 0 && gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
        end
        s = pending_segs[0];
        in_valid     <= 1'b1;
        in_origin_x  <= s.ox;
        in_origin_y  <= s.oy;
        in_origin_z  <= s.oz;
        in_dir_x     <= s.dx;
        in_dir_y     <= s.dy;
        in_thickness <= s.t;
      end
    end
  end

  // receiver: stall pattern changes phase every so often
  always @(posedge clk) begin
    if (($urandom_range(0, 199)) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= (cycles % 7) < 3;
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  always @(posedge clk) begin
    corner_t c;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_corners.size() == 0) begin
        report("unexpected corner word", 64'(out_corner_index), '0);
      end else begin
        c = expected_corners.pop_front();
        if (out_corner_index !== c.idx) report("corner_index", out_corner_index, c.idx);
        if (out_corner_x !== c.x) report("corner_x", out_corner_x, c.x);
        if (out_corner_y !== c.y) report("corner_y", out_corner_y, c.y);
        if (out_corner_z !== c.z) report("corner_z", out_corner_z, c.z);
        if (out_normal_x_pos !== c.nxp) report("normal_x_pos", out_normal_x_pos, c.nxp);
        if (out_normal_y_pos !== c.nyp) report("normal_y_pos", out_normal_y_pos, c.nyp);
        if (out_seg_length !== c.len) report("seg_length", out_seg_length, c.len);
        if (out_seg_width !== c.w) report("seg_width", out_seg_width, c.w);
        if (out_last !== c.last) report("last", out_last, c.last);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    wait (expected_corners.size() == 0);
    repeat (150) @(posedge clk);
    if (mismatches == 0 && expected_corners.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
